>>> src/flg_pkg.sv
`timescale 1ns / 1ps
package flg_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int DEPTH_LOG2 = 11;
	localparam int DELAY_DEPTH = 2 ** DEPTH_LOG2;
	localparam int FR_W       = 16;
	localparam int QK_W       = DEPTH_LOG2 + FR_W;
	localparam int MUL_W      = 33;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int EXT_W      = PROD_W + 1;
	localparam int WX_W       = 43;
	localparam int OSC_W      = 32;
	localparam int DVD_W      = 39;
	localparam int DIVISOR    = 1000;
	localparam int RECIP_W    = 32;
	localparam int RECIP_SH   = 41;
	localparam int SPLIT_W    = 20;
	localparam int PLO_W      = SPLIT_W + RECIP_W;
	localparam int SUM_W      = RECIP_SH + QK_W;
	localparam int REM_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// floor(2^41 / 1000)
	localparam logic [RECIP_W-1:0] RECIP = 32'd2199023255;

	localparam logic [17:0] SR_MAX = 18'd192000;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OSC_COS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OSC_SIN     = 3'd4;

	localparam logic [17:0]              RST_SAMPLE_RATE = 18'd48000;
	localparam logic [17:0]              RST_WET_GAIN    = 18'd41645;
	localparam logic [16:0]              RST_DRY_GAIN    = 17'd13107;
	localparam logic signed [OSC_W-1:0] RST_OSC_COS     = 32'sd1073741824;
	localparam logic signed [OSC_W-1:0] RST_OSC_SIN     = 32'sd28110;

	typedef struct packed {
		logic                  en;
		logic [DEPTH_LOG2-1:0] addr;
		logic [SAMPLE_W-1:0]   data;
	} dline_wr_t;

	localparam logic signed [EXT_W-1:0] S_HI =
		{{(EXT_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
	localparam logic signed [EXT_W-1:0] O_HI =
		{{(EXT_W - OSC_W + 1){1'b0}}, {(OSC_W - 1){1'b1}}};

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [EXT_W-1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > S_HI)
			r = S_HI[SAMPLE_W-1:0];
		else if (v < ~S_HI)
			r = ~S_HI[SAMPLE_W-1:0];
		else
			r = v[SAMPLE_W-1:0];
		return r;
	endfunction

	function automatic logic signed [OSC_W-1:0] sat_osc(input logic signed [EXT_W-1:0] v);
		logic signed [OSC_W-1:0] r;
		if (v > O_HI)
			r = O_HI[OSC_W-1:0];
		else if (v < ~O_HI)
			r = ~O_HI[OSC_W-1:0];
		else
			r = v[OSC_W-1:0];
		return r;
	endfunction

endpackage

>>> src/flg_in_if.sv
`timescale 1ns / 1ps
interface flg_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [flg_pkg::SAMPLE_W-1:0] in_sample;
	logic                                 last_in_block;

	modport source(output valid, in_sample, last_in_block, input ready);
	modport sink(input valid, in_sample, last_in_block, output ready);
endinterface

>>> src/flg_out_if.sv
`timescale 1ns / 1ps
interface flg_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [flg_pkg::SAMPLE_W-1:0] out_sample;
	logic                                 last_out_block;

	modport source(output valid, out_sample, last_out_block, input ready);
	modport sink(input valid, out_sample, last_out_block, output ready);
endinterface

>>> src/flg_mul.sv
`timescale 1ns / 1ps
module flg_mul (
	input  logic                               clk,
	input  logic signed [flg_pkg::MUL_W-1:0]  a,
	input  logic signed [flg_pkg::MUL_W-1:0]  b,
	output logic signed [flg_pkg::PROD_W-1:0] prod
);
	import flg_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_s1;
endmodule

>>> src/flg_div.sv
`timescale 1ns / 1ps
module flg_div (
	input  logic                              clk,
	input  logic                              load,
	input  logic                              upper,
	input  logic                              lo_en,
	input  logic                              hi_en,
	input  logic                              fix_en,
	input  logic [flg_pkg::DVD_W-1:0]         dividend,
	input  logic signed [flg_pkg::PROD_W-1:0] prod,
	output logic [flg_pkg::MUL_W-1:0]         opnd,
	output logic [flg_pkg::QK_W-1:0]          quot
);
	import flg_pkg::*;

	logic [DVD_W-1:0] dvd_q;
	logic [PLO_W-1:0] plo_q;
	logic [QK_W-1:0]  est_q, quot_q;
	logic [SUM_W-1:0] sum;
	logic [REM_W-1:0] rem;

	// estimate is the quotient or one below it; the remainder fixes it
	always_comb begin
		opnd = upper ? MUL_W'(dvd_q[DVD_W-1:SPLIT_W]) : MUL_W'(dvd_q[SPLIT_W-1:0]);
		sum  = {prod[SUM_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}} + SUM_W'(plo_q);
		rem  = dvd_q[REM_W-1:0]
			- ({est_q[1:0], 10'd0} - {est_q[7:0], 4'd0} - {est_q[8:0], 3'd0});
	end

	always_ff @(posedge clk) begin
		if (load)
			dvd_q <= dividend;
		if (lo_en)
			plo_q <= prod[PLO_W-1:0];
		if (hi_en)
			est_q <= sum[SUM_W-1:RECIP_SH];
		if (fix_en)
			quot_q <= est_q + QK_W'(rem >= REM_W'(DIVISOR));
	end

	assign quot = quot_q;
endmodule

>>> src/flg_dline.sv
`timescale 1ns / 1ps
module flg_dline (
	input  logic                               clk,
	input  flg_pkg::dline_wr_t                 wr,
	input  logic [flg_pkg::DEPTH_LOG2-1:0]     rd_addr,
	output logic [flg_pkg::SAMPLE_W-1:0]       rd_data
);
	import flg_pkg::*;

	logic [SAMPLE_W-1:0] mem [DELAY_DEPTH];
	logic [SAMPLE_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr] <= wr.data;
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;
endmodule

>>> src/audio_flanger.sv
`timescale 1ns / 1ps
// Samples are handled one at a time: after the accept state, each runs a fixed
// 18-step sequence on the shared multiplier (divide by 1000 done by reciprocal
// multiply); a result still held on the output stalls it in its last step.
// Reset: async active low; delay line reads as zero until each entry is
// first written (tracked by write pointer and wrap flag, no clearing pass).
module audio_flanger (
	input  logic                                 clk,
	input  logic                                 arst_n,
	flg_in_if.sink                               in_ch,
	flg_out_if.source                            out_ch,
	input  logic                                 cfg_wr_en,
	input  logic [flg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [flg_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import flg_pkg::*;

	typedef enum logic [18:0] {
		ST_IDLE = 19'h00001,
		ST_WX   = 19'h00002,
		ST_P1   = 19'h00004,
		ST_P2   = 19'h00008,
		ST_P3   = 19'h00010,
		ST_P4   = 19'h00020,
		ST_OSC  = 19'h00040,
		ST_DLO  = 19'h00080,
		ST_DHI  = 19'h00100,
		ST_RLO  = 19'h00200,
		ST_RHI  = 19'h00400,
		ST_QE   = 19'h00800,
		ST_QC   = 19'h01000,
		ST_TAP  = 19'h02000,
		ST_RDA  = 19'h04000,
		ST_RDB  = 19'h08000,
		ST_INT  = 19'h10000,
		ST_FB   = 19'h20000,
		ST_OUT  = 19'h40000
	} state_t;

	localparam logic signed [EXT_W-1:0] HALF_16 = EXT_W'(1) <<< 15;
	localparam logic signed [EXT_W-1:0] HALF_17 = EXT_W'(1) <<< 16;
	localparam logic signed [EXT_W-1:0] HALF_30 = EXT_W'(1) <<< 29;
	localparam logic signed [EXT_W-1:0] ONE_30  = EXT_W'(1) <<< 30;
	localparam logic signed [35:0]      U_OFS   = 36'sd6 <<< 30;

	state_t state_q;

	logic [17:0]              sr_q, wet_q;
	logic [16:0]              dry_q;
	logic signed [OSC_W-1:0]  cos_q, sin_q;

	logic signed [SAMPLE_W-1:0] x_q, fb_q, a_q, out_q;
	logic                       last_q, out_last_q, out_valid_q;
	logic signed [WX_W-1:0]     wx_q;
	logic signed [EXT_W-1:0]    acc_q;
	logic signed [OSC_W-1:0]    ss_q, cs_q, s_tmp_q;
	logic                       started_q, sign_q, wrapped_q, rd_vld_s1;
	logic [DEPTH_LOG2-1:0]      wi_q, ipa_q;
	logic [FR_W-1:0]            fr_q;

	logic [17:0]                sr_c;
	logic signed [MUL_W-1:0]    mul_a, mul_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [35:0]         u;
	logic signed [EXT_W-1:0]    line_v, s_sum, c_sum, c_r, n_sh, fb_v, o_v;
	logic                       n_sgn;
	logic [DVD_W-1:0]           dvd;
	logic [MUL_W-1:0]           d_opnd;
	logic [QK_W-1:0]            quot, q_fix;
	dline_wr_t                  dl_wr;
	logic [DEPTH_LOG2-1:0]      rd_addr;
	logic [SAMPLE_W-1:0]        rd_data;
	logic signed [SAMPLE_W-1:0] rd_val;
	logic signed [SAMPLE_W:0]   tap_diff;
	logic                       out_free;

	flg_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

	flg_div u_div (
		.clk(clk), .load(state_q == ST_DHI), .upper(state_q == ST_RHI),
		.lo_en(state_q == ST_RHI), .hi_en(state_q == ST_QE), .fix_en(state_q == ST_QC),
		.dividend(dvd), .prod(prod), .opnd(d_opnd), .quot(quot)
	);

	flg_dline u_dline (.clk(clk), .wr(dl_wr), .rd_addr(rd_addr), .rd_data(rd_data));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_q  <= RST_SAMPLE_RATE;
			wet_q <= RST_WET_GAIN;
			dry_q <= RST_DRY_GAIN;
			cos_q <= RST_OSC_COS;
			sin_q <= RST_OSC_SIN;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SAMPLE_RATE: sr_q  <= cfg_data[17:0];
				REG_WET_GAIN:    wet_q <= cfg_data[17:0];
				REG_DRY_GAIN:    dry_q <= cfg_data[16:0];
				REG_OSC_COS:     cos_q <= cfg_data;
				REG_OSC_SIN:     sin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (sr_q == '0)
			sr_c = 18'd1;
		else if (sr_q > SR_MAX)
			sr_c = SR_MAX;
		else
			sr_c = sr_q;
		u        = (36'(s_tmp_q) <<< 2) + 36'(s_tmp_q) + U_OFS;
		line_v   = (EXT_W'(fb_q) <<< 16) - (EXT_W'(prod) <<< 1);
		s_sum    = acc_q + EXT_W'(prod);
		c_sum    = acc_q - EXT_W'(prod);
		c_r      = ((c_sum + HALF_30) >>> 30) + (started_q ? EXT_W'(0) : ONE_30);
		n_sh     = ((EXT_W'(prod) <<< 18) + acc_q) >>> 14;
		n_sgn    = n_sh[EXT_W-1];
		dvd      = n_sh[DVD_W-1:0] ^ {DVD_W{n_sgn}};
		q_fix    = quot ^ {QK_W{sign_q}};
		rd_val   = rd_vld_s1 ? rd_data : '0;
		tap_diff = (SAMPLE_W + 1)'(rd_val) - (SAMPLE_W + 1)'(a_q);
		fb_v     = (EXT_W'(a_q) <<< 16) + EXT_W'(prod);
		o_v      = (EXT_W'(prod) <<< 1) + EXT_W'(wx_q) - (EXT_W'(fb_q) <<< 16);
		out_free = !out_valid_q || out_ch.ready;

		dl_wr.en   = state_q == ST_P1;
		dl_wr.addr = wi_q;
		dl_wr.data = sat_sample((line_v + HALF_17) >>> 17);
		rd_addr    = (state_q == ST_RDB) ? ipa_q - 1'b1 : ipa_q;

		unique case (state_q)
			ST_WX: begin
				mul_a = MUL_W'($signed({1'b0, wet_q}));
				mul_b = MUL_W'(x_q);
			end
			ST_P1: begin
				mul_a = MUL_W'(sin_q);
				mul_b = MUL_W'(cs_q);
			end
			ST_P2: begin
				mul_a = MUL_W'(cos_q);
				mul_b = MUL_W'(ss_q);
			end
			ST_P3: begin
				mul_a = MUL_W'(cos_q);
				mul_b = MUL_W'(cs_q);
			end
			ST_P4: begin
				mul_a = MUL_W'(sin_q);
				mul_b = MUL_W'(ss_q);
			end
			ST_OSC: begin
				mul_a = MUL_W'($signed({1'b0, sr_c}));
				mul_b = MUL_W'($signed({1'b0, u[17:0]}));
			end
			ST_DLO: begin
				mul_a = MUL_W'($signed({1'b0, sr_c}));
				mul_b = MUL_W'($signed(u[35:18]));
			end
			ST_RLO: begin
				mul_a = MUL_W'($signed({1'b0, RECIP}));
				mul_b = $signed(d_opnd);
			end
			ST_RHI: begin
				mul_a = MUL_W'($signed({1'b0, RECIP}));
				mul_b = $signed(d_opnd);
			end
			ST_INT: begin
				mul_a = MUL_W'(tap_diff);
				mul_b = MUL_W'($signed({1'b0, fr_q}));
			end
			ST_FB: begin
				mul_a = MUL_W'($signed({1'b0, dry_q}));
				mul_b = MUL_W'(x_q);
			end
			ST_OUT: begin
				mul_a = MUL_W'($signed({1'b0, dry_q}));
				mul_b = MUL_W'(x_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			wi_q        <= '0;
			wrapped_q   <= 1'b0;
			fb_q        <= '0;
			ss_q        <= '0;
			cs_q        <= '0;
			started_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_ch.valid) state_q <= ST_WX;
				ST_WX:   state_q <= ST_P1;
				ST_P1:   state_q <= ST_P2;
				ST_P2:   state_q <= ST_P3;
				ST_P3:   state_q <= ST_P4;
				ST_P4:   state_q <= ST_OSC;
				ST_OSC: begin
					ss_q      <= s_tmp_q;
					cs_q      <= sat_osc(c_r);
					started_q <= 1'b1;
					state_q   <= ST_DLO;
				end
				ST_DLO:  state_q <= ST_DHI;
				ST_DHI:  state_q <= ST_RLO;
				ST_RLO:  state_q <= ST_RHI;
				ST_RHI:  state_q <= ST_QE;
				ST_QE:   state_q <= ST_QC;
				ST_QC:   state_q <= ST_TAP;
				ST_TAP:  state_q <= ST_RDA;
				ST_RDA:  state_q <= ST_RDB;
				ST_RDB:  state_q <= ST_INT;
				ST_INT:  state_q <= ST_FB;
				ST_FB: begin
					fb_q    <= sat_sample((fb_v + HALF_16) >>> 16);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						wi_q        <= wi_q + 1'b1;
						wrapped_q   <= wrapped_q | (&wi_q);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			x_q    <= in_ch.in_sample;
			last_q <= in_ch.last_in_block;
		end
		if (state_q == ST_P1)
			wx_q <= prod[WX_W-1:0];
		if (state_q == ST_P2 || state_q == ST_P4 || state_q == ST_DLO)
			acc_q <= EXT_W'(prod);
		if (state_q == ST_P3)
			s_tmp_q <= sat_osc((s_sum + HALF_30) >>> 30);
		if (state_q == ST_DHI)
			sign_q <= n_sgn;
		if (state_q == ST_TAP) begin
			ipa_q <= wi_q - q_fix[QK_W-1:FR_W];
			fr_q  <= q_fix[FR_W-1:0];
		end
		if (state_q == ST_RDA || state_q == ST_RDB)
			rd_vld_s1 <= wrapped_q || (rd_addr <= wi_q);
		if (state_q == ST_RDB)
			a_q <= rd_val;
		if (state_q == ST_OUT && out_free) begin
			out_q      <= sat_sample((o_v + HALF_17) >>> 17);
			out_last_q <= last_q;
		end
	end

	assign in_ch.ready           = state_q == ST_IDLE;
	assign out_ch.valid          = out_valid_q;
	assign out_ch.out_sample     = out_q;
	assign out_ch.last_out_block = out_last_q;
endmodule

>>> verif/flg_checker.sv
`timescale 1ns / 1ps
module flg_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	flg_in_if                                    in_ch,
	flg_out_if                                   out_ch,
	input  logic                                 cfg_wr_en,
	input  logic [flg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [flg_pkg::CFG_DATA_W-1:0]       cfg_data,
	output int                                   errs,
	output int                                   pending
);
	import flg_pkg::*;

	typedef struct {
		logic signed [SAMPLE_W-1:0] smp;
		logic                       lst;
	} flanged_t;

	localparam longint LINE_N = DELAY_DEPTH;
	localparam longint S_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
	localparam longint O_MAX = 64'sd2147483647;

	longint    rate_reg, wet_reg, dry_reg, cos_reg, sin_reg;
	longint    dline [DELAY_DEPTH];
	longint    wr_idx, fb_val, osc_s, osc_c;
	bit        kicked;
	flanged_t  expected_q[$];

	assign pending = expected_q.size();

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint rnd_shift(input longint v, input int k);
		return (v + (64'sd1 <<< (k - 1))) >>> k;
	endfunction

	function automatic longint line_pos(input longint back);
		longint m;
		m = back % LINE_N;
		if (m < 0)
			m += LINE_N;
		return (wr_idx + LINE_N - m) % LINE_N;
	endfunction

	function automatic flanged_t flange(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
		longint   x, wx, s_new, c_new, sr, num, dq, ip, fr, a, b, fbv, acc;
		flanged_t r;
		x = smp;
		wx = wet_reg * x;
		dline[wr_idx] = clip(rnd_shift(fb_val * 65536 - 2 * wx, 17), -S_MAX - 1, S_MAX);
		s_new = rnd_shift(sin_reg * osc_c + cos_reg * osc_s, 30);
		c_new = rnd_shift(cos_reg * osc_c - sin_reg * osc_s, 30);
		if (!kicked)
			c_new += 64'sd1 <<< 30;
		osc_s = clip(s_new, -O_MAX - 1, O_MAX);
		osc_c = clip(c_new, -O_MAX - 1, O_MAX);
		kicked = 1'b1;
		sr = clip(rate_reg, 1, 192000);
		num = sr * (5 * (osc_s + (64'sd1 <<< 30)) + (64'sd1 <<< 30));
		dq = num / 16384000;
		if (num % 16384000 != 0 && num < 0)
			dq -= 1;
		ip = dq >>> 16;
		fr = dq - ip * 65536;
		a = dline[line_pos(ip)];
		b = dline[line_pos(ip + 1)];
		fbv = clip(rnd_shift(a * (65536 - fr) + b * fr, 16), -S_MAX - 1, S_MAX);
		fb_val = fbv;
		acc = 2 * dry_reg * x + wx - fbv * 65536;
		r.smp = clip(rnd_shift(acc, 17), -S_MAX - 1, S_MAX);
		r.lst = lst;
		wr_idx = (wr_idx + 1) % LINE_N;
		return r;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("%0t: %s got %0d expected %0d", $time, what, got, want);
		errs++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		flanged_t e;
		if (!arst_n) begin
			errs = 0;
			rate_reg = RST_SAMPLE_RATE;
			wet_reg = RST_WET_GAIN;
			dry_reg = RST_DRY_GAIN;
			cos_reg = RST_OSC_COS;
			sin_reg = RST_OSC_SIN;
			foreach (dline[i])
				dline[i] = 0;
			wr_idx = 0;
			fb_val = 0;
			osc_s = 0;
			osc_c = 0;
			kicked = 1'b0;
			expected_q.delete();
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected beat", out_ch.out_sample, 0);
				end else begin
					e = expected_q.pop_front();
					if (out_ch.out_sample !== e.smp)
						report("out_sample", out_ch.out_sample, e.smp);
					if (out_ch.last_out_block !== e.lst)
						report("last_out_block", out_ch.last_out_block, e.lst);
				end
			end
			if (in_ch.valid && in_ch.ready)
				expected_q.push_back(flange(in_ch.in_sample, in_ch.last_in_block));
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SAMPLE_RATE: rate_reg = cfg_data[17:0];
					REG_WET_GAIN:    wet_reg = cfg_data[17:0];
					REG_DRY_GAIN:    dry_reg = cfg_data[16:0];
					REG_OSC_COS:     cos_reg = longint'($signed(cfg_data));
					REG_OSC_SIN:     sin_reg = longint'($signed(cfg_data));
					default: ;
				endcase
			end
		end
	end
endmodule

>>> verif/audio_flanger_tb.sv
`timescale 1ns / 1ps
module audio_flanger_tb;
	import flg_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errs, pending;
	int                    tx_idle, rx_idle;
	int                    hold_req, hold_seen, hold_left;
	int                    quiet;

	flg_in_if  in_ch();
	flg_out_if out_ch();

	audio_flanger dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	flg_checker chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errs(errs), .pending(pending)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready = 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
			out_ch.ready = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ch.ready = 1'b0;
		end else begin
			out_ch.ready = ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("audio_flanger: mismatch");
			$finish;
		end
	end

	task automatic send(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
		while ($urandom_range(99) < tx_idle) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.in_sample = smp;
		in_ch.last_in_block = lst;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic settle();
		in_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(3))
			0: return SAMPLE_W'($urandom());
			1: return SAMPLE_W'($signed($urandom_range(4095)) - 2048);
			2: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
			default: return $urandom_range(1)
				? 24'sh700000 + SAMPLE_W'($urandom_range(65535))
				: 24'sh900000 - SAMPLE_W'($urandom_range(65535));
		endcase
	endfunction

	task automatic run_random(input int n);
		for (int i = 0; i < n; i++)
			send(pick_sample(), 1'($urandom_range(1)));
	endtask

	task automatic set_idle(input int phase);
		case (phase % 3)
			0: begin tx_idle = 32; rx_idle = 83; end
			1: begin tx_idle = 83; rx_idle = 32; end
			default: begin tx_idle = 0; rx_idle = 0; end
		endcase
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_SAMPLE_RATE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.in_sample = '0;
		in_ch.last_in_block = 1'b0;
		tx_idle = 0;
		rx_idle = 0;
		hold_req = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes at reset settings
		set_idle(0);
		send(24'sh7fffff, 1'b0);
		send(24'sh800000, 1'b1);
		send(24'sh000000, 1'b0);
		send(24'sh000001, 1'b1);
		send(24'shffffff, 1'b0);
		send(24'sh555555, 1'b1);
		send(24'shaaaaaa, 1'b0);
		for (int i = 0; i < 8; i++)
			send(i[0] ? 24'sh7fffff : 24'sh800000, i[1]);
		settle();

		// sample rate zero clamps up, oversized rate clamps down
		write_reg(REG_SAMPLE_RATE, 32'd0);
		write_reg(REG_WET_GAIN, 32'd207243);
		write_reg(REG_DRY_GAIN, 32'd65536);
		set_idle(0);
		run_random(80);
		settle();

		write_reg(REG_SAMPLE_RATE, 32'h3ffff);
		write_reg(REG_WET_GAIN, 32'd0);
		write_reg(REG_DRY_GAIN, 32'd0);
		set_idle(1);
		run_random(80);
		settle();

		// fast oscillator: delay sweeps across the whole line
		write_reg(REG_SAMPLE_RATE, 32'd192000);
		write_reg(REG_WET_GAIN, 32'd207243);
		write_reg(REG_DRY_GAIN, 32'd32768);
		write_reg(REG_OSC_COS, 32'd0);
		write_reg(REG_OSC_SIN, 32'h40000000);
		set_idle(2);
		hold_req++;
		run_random(90);
		settle();

		// gain above unity: oscillator saturates, delay goes negative
		write_reg(REG_OSC_COS, 32'h40000000);
		write_reg(REG_OSC_SIN, 32'h40000000);
		write_reg(REG_SAMPLE_RATE, 32'd1);
		set_idle(0);
		run_random(90);
		settle();

		write_reg(REG_OSC_COS, 32'hc0000000);
		write_reg(REG_OSC_SIN, 32'hc0000000);
		write_reg(REG_SAMPLE_RATE, 32'd96000);
		write_reg(REG_WET_GAIN, 32'd100000);
		write_reg(REG_DRY_GAIN, 32'd13107);
		set_idle(1);
		run_random(90);
		settle();

		write_reg(REG_OSC_COS, 32'h3fffe000);
		write_reg(REG_OSC_SIN, 32'd2000000);
		write_reg(REG_SAMPLE_RATE, 32'd44100);
		write_reg(REG_WET_GAIN, 32'd41645);
		set_idle(2);
		run_random(110);
		settle();

		if (errs == 0)
			$display("audio_flanger: match");
		else
			$display("audio_flanger: mismatch");
		$finish;
	end
endmodule

>>> audio_flanger.f
src/flg_pkg.sv
src/flg_in_if.sv
src/flg_out_if.sv
src/flg_mul.sv
src/flg_div.sv
src/flg_dline.sv
src/audio_flanger.sv
verif/flg_checker.sv
verif/audio_flanger_tb.sv
